FILE: rtl/kh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kh_pkg
// Types, codes and small tables shared by the keyer host command parser.
// ----------------------------------------------------------------------------
package kh_pkg;

   typedef enum logic [1:0] {
      CMD_HOST  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_SPEED = 2'd2,
      CMD_ECHO  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      EV_HOST  = 3'd0,
      EV_SPEED = 3'd1,
      EV_TONE  = 3'd2,
      EV_STOP  = 3'd3,
      EV_KEY   = 3'd4,
      EV_TEXT  = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      PM_IDLE   = 2'd0,
      PM_ADMIN  = 2'd1,
      PM_PARAMS = 2'd2
   } parse_mode_type;

   // admin sub-commands
   localparam logic [7:0] ADM_RESET  = 8'h01;
   localparam logic [7:0] ADM_OPEN   = 8'h02;
   localparam logic [7:0] ADM_CLOSE  = 8'h03;
   localparam logic [7:0] ADM_VALUES = 8'h07;
   localparam logic [7:0] ADM_WK1    = 8'h0A;
   localparam logic [7:0] ADM_WK2    = 8'h0B;

   // host commands
   localparam logic [4:0] HC_TONE    = 5'h01;
   localparam logic [4:0] HC_SPEED   = 5'h02;
   localparam logic [4:0] HC_WEIGHT  = 5'h03;
   localparam logic [4:0] HC_PTT     = 5'h04;
   localparam logic [4:0] HC_POTSET  = 5'h05;
   localparam logic [4:0] HC_GETPOT  = 5'h07;
   localparam logic [4:0] HC_BKSP    = 5'h08;
   localparam logic [4:0] HC_CLEAR   = 5'h0A;
   localparam logic [4:0] HC_KEY     = 5'h0B;
   localparam logic [4:0] HC_FARNS   = 5'h0D;
   localparam logic [4:0] HC_MODE    = 5'h0E;
   localparam logic [4:0] HC_BUFFER  = 5'h0F;
   localparam logic [4:0] HC_NOP13   = 5'h13;
   localparam logic [4:0] HC_STATUS  = 5'h15;
   localparam logic [4:0] HC_RATIO   = 5'h17;
   localparam logic [4:0] HC_NOP1B   = 5'h1B;
   localparam logic [4:0] HC_NOP1E   = 5'h1E;
   localparam logic [4:0] HC_NOP1F   = 5'h1F;

   // configuration register indexes
   localparam logic [1:0] REG_VERSION  = 2'd0;
   localparam logic [1:0] REG_POT_LOW  = 2'd1;
   localparam logic [1:0] REG_POT_HIGH = 2'd2;

   localparam logic [7:0] VERSION_RST  = 8'd23;
   localparam logic [6:0] POT_LOW_RST  = 7'd5;
   localparam logic [6:0] POT_HIGH_RST = 7'd99;
   localparam logic [6:0] SPEED_RST    = 7'd20;
   localparam logic [7:0] WPM_NONE     = 8'hFF;
   localparam logic [7:0] STATUS_BASE  = 8'hC0;
   localparam logic [7:0] STATUS_XOFF  = 8'h11;
   localparam logic [7:0] STATUS_BUSY  = 8'h04;
   localparam logic [3:0] VALUES_LAST  = 4'd13;
   localparam int         MAX_DRAIN    = 32;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic       consumer_busy;
      logic [6:0] local_wpm;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [11:0] value;
      logic        last;
      logic        continuation;
   } rsp_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       busy;
      logic [6:0] wpm;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } link_type;

   function automatic logic [6:0] sat_wpm(input logic [7:0] v);
      logic [6:0] r;
      if (v < 8'd5) r = 7'd5;
      else if (v > 8'd99) r = 7'd99;
      else r = v[6:0];
      return r;
   endfunction

   function automatic logic [7:0] upcase(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h20;
      return r;
   endfunction

   function automatic logic [11:0] tone_hz(input logic [3:0] i);
      logic [11:0] r;
      case (i)
         4'd1:    r = 12'd4000;
         4'd2:    r = 12'd2000;
         4'd3:    r = 12'd1333;
         4'd4:    r = 12'd1000;
         4'd5:    r = 12'd800;
         4'd6:    r = 12'd667;
         4'd7:    r = 12'd571;
         4'd8:    r = 12'd500;
         4'd9:    r = 12'd444;
         4'd10:   r = 12'd400;
         default: r = 12'd600;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] arity(input logic [4:0] c);
      logic [3:0] r;
      case (c)
         HC_PTT:    r = 4'd2;
         HC_POTSET: r = 4'd3;
         HC_BUFFER: r = 4'd15;
         HC_GETPOT, HC_BKSP, HC_CLEAR, HC_NOP13, HC_STATUS,
         HC_NOP1B, HC_NOP1E, HC_NOP1F: r = 4'd0;
         default:   r = 4'd1;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] pot_byte(input logic [6:0] spd, input logic [6:0] lo);
      logic [6:0] off;
      off = (spd > lo) ? spd - lo : 7'd0;
      return {1'b1, off};
   endfunction

endpackage

FILE: rtl/kh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kh_front
// Input stage: accepts items, classifies the command and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module kh_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kh_pkg::req_type  req_data,
   output kh_pkg::link_type link,
   input  logic             pop
);

   kh_pkg::item_type buf_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push;
   logic             take;
   kh_pkg::item_type item_new;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign take      = pop && (cnt_ff != 2'd0);

   always_comb begin
      item_new.cmd       = kh_pkg::cmd_type'(req_data.command);
      item_new.data_byte = req_data.data_byte;
      item_new.busy      = req_data.consumer_busy;
      item_new.wpm       = req_data.local_wpm;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, take};
   end

   assign link.valid = (cnt_ff != 2'd0);
   assign link.item  = buf_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

FILE: rtl/kh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kh_back
// Execution stage: parses host bytes, runs commands, keeps the text queue
// and streams results through the output register.
// ----------------------------------------------------------------------------
module kh_back #(
   parameter int QUEUE_DEPTH = 32,
   parameter int XOFF_LEVEL  = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  kh_pkg::link_type link,
   output logic             pop,
   input  logic [7:0]       cfg_version,
   input  logic [6:0]       cfg_pot_low,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kh_pkg::rsp_type  rsp_data
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = AW + 1;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_ACT      = 6'b000010,
      ST_EMIT     = 6'b000100,
      ST_VALS     = 6'b001000,
      ST_DRAIN_RD = 6'b010000,
      ST_DRAIN_WR = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   kh_pkg::parse_mode_type mode_ff, mode_in;
   logic [4:0]             pend_ff, pend_in;
   logic [3:0]             seen_ff, seen_in;
   logic [3:0]             want_ff, want_in;
   logic [7:0]             p0_ff, p0_in;
   logic                   open_ff, open_in;
   logic                   primed_ff, primed_in;
   logic [6:0]             speed_ff, speed_in;
   logic [7:0]             pushed_ff, pushed_in;
   logic [6:0]             potlo_ff, potlo_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [AW-1:0]          head_ff, head_in;
   logic                   cont_ff, cont_in;
   logic                   pbusy_ff, pbusy_in;
   logic                   pne_ff, pne_in;
   logic [5:0]             rem_ff, rem_in;
   logic [3:0]             vals_ff, vals_in;
   logic                   dcont_ff, dcont_in;
   kh_pkg::rsp_type        res_ff, res_in;
   logic                   out_valid_ff, out_valid_in;
   kh_pkg::rsp_type        out_data_ff, out_data_in;
   logic [7:0]             rdq_ff;
   logic [7:0]             mem [QUEUE_DEPTH];

   logic                   out_free;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [7:0]             mem_wdata;
   logic [SW-1:0]          tail_sum;
   logic [AW-1:0]          head_nx;
   logic [3:0]             seen_nx;
   logic [7:0]             b;
   logic [7:0]             up;
   logic [3:0]             n_args;
   logic [6:0]             wpm_c;
   logic                   went_idle;
   logic                   cont_now;
   logic [7:0]             status;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      tail_sum = {1'b0, head_ff} + SW'(cnt_ff);
      if (32'(tail_sum) >= QUEUE_DEPTH) tail_sum = tail_sum - SW'(QUEUE_DEPTH);
      head_nx = (32'(head_ff) == QUEUE_DEPTH - 1) ? '0 : head_ff + AW'(1);
      seen_nx = seen_ff + 4'd1;
      b       = link.item.data_byte;
      up      = kh_pkg::upcase(b);
      n_args  = kh_pkg::arity(b[4:0]);
      wpm_c   = kh_pkg::sat_wpm({1'b0, link.item.wpm});
      went_idle = pbusy_ff && !link.item.busy;
      cont_now  = went_idle ? pne_ff : cont_ff;
      status  = kh_pkg::STATUS_BASE;
      if (32'(cnt_ff) >= XOFF_LEVEL) status = status | kh_pkg::STATUS_XOFF;
      if (cnt_ff != '0) status = status | kh_pkg::STATUS_BUSY;
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      seen_in   = seen_ff;
      want_in   = want_ff;
      p0_in     = p0_ff;
      open_in   = open_ff;
      primed_in = primed_ff;
      speed_in  = speed_ff;
      pushed_in = pushed_ff;
      potlo_in  = potlo_ff;
      cnt_in    = cnt_ff;
      head_in   = head_ff;
      cont_in   = cont_ff;
      pbusy_in  = pbusy_ff;
      pne_in    = pne_ff;
      rem_in    = rem_ff;
      vals_in   = vals_ff;
      dcont_in  = dcont_ff;
      res_in    = res_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      pop       = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = tail_sum[AW-1:0];
      mem_wdata = up;

      case (state_ff)
         ST_IDLE: begin
            if (link.valid) begin
               pop = 1'b1;
               res_in.last         = 1'b1;
               res_in.continuation = 1'b0;
               case (link.item.cmd)
                  kh_pkg::CMD_HOST: begin
                     case (mode_ff)
                        kh_pkg::PM_ADMIN: begin
                           mode_in = kh_pkg::PM_IDLE;
                           case (b)
                              kh_pkg::ADM_OPEN: begin
                                 open_in         = 1'b1;
                                 res_in.event_res = kh_pkg::EV_HOST;
                                 res_in.value     = {4'd0, cfg_version};
                                 state_in         = ST_EMIT;
                              end
                              kh_pkg::ADM_CLOSE: open_in = 1'b0;
                              kh_pkg::ADM_VALUES: begin
                                 vals_in  = 4'd0;
                                 state_in = ST_VALS;
                              end
                              kh_pkg::ADM_RESET: begin
                                 pend_in   = 5'd0;
                                 seen_in   = 4'd0;
                                 want_in   = 4'd0;
                                 speed_in  = kh_pkg::SPEED_RST;
                                 pushed_in = kh_pkg::WPM_NONE;
                                 potlo_in  = kh_pkg::sat_wpm({1'b0, cfg_pot_low});
                                 cnt_in    = '0;
                                 head_in   = '0;
                                 primed_in = 1'b0;
                                 cont_in   = 1'b0;
                                 pbusy_in  = 1'b0;
                                 pne_in    = 1'b0;
                              end
                              // mode switches leave nothing visible here
                              default: ;
                           endcase
                        end
                        kh_pkg::PM_PARAMS: begin
                           if (seen_ff == 4'd0) p0_in = b;
                           seen_in = seen_nx;
                           if (seen_nx >= want_ff) begin
                              mode_in  = kh_pkg::PM_IDLE;
                              state_in = ST_ACT;
                           end
                        end
                        default: begin
                           mode_in = kh_pkg::PM_IDLE;
                           if (b == 8'd0) begin
                              mode_in = kh_pkg::PM_ADMIN;
                           end else if (b >= 8'h20) begin
                              if (open_ff && primed_ff) begin
                                 if (32'(cnt_ff) < QUEUE_DEPTH) begin
                                    mem_we = 1'b1;
                                    cnt_in = cnt_ff + CW'(1);
                                 end
                                 res_in.event_res = kh_pkg::EV_HOST;
                                 res_in.value     = {4'd0, up};
                                 state_in         = ST_EMIT;
                              end
                           end else if (open_ff) begin
                              pend_in = b[4:0];
                              if (n_args == 4'd0) begin
                                 state_in = ST_ACT;
                              end else begin
                                 mode_in = kh_pkg::PM_PARAMS;
                                 want_in = n_args;
                                 seen_in = 4'd0;
                              end
                           end
                        end
                     endcase
                  end
                  kh_pkg::CMD_TICK: begin
                     pbusy_in = link.item.busy;
                     if (cnt_ff == '0) begin
                        if (went_idle) cont_in = 1'b0;
                        pne_in = 1'b0;
                     end else begin
                        cont_in = cont_now;
                        pne_in  = 1'b1;
                        if (!link.item.busy) begin
                           dcont_in = cont_now;
                           cont_in  = 1'b1;
                           rem_in   = (32'(cnt_ff) > kh_pkg::MAX_DRAIN) ?
                                      6'(kh_pkg::MAX_DRAIN) : 6'(cnt_ff);
                           state_in = ST_DRAIN_RD;
                        end
                     end
                  end
                  kh_pkg::CMD_SPEED: begin
                     if (!({1'b0, wpm_c} == {1'b0, speed_ff} && {1'b0, wpm_c} == pushed_ff))
                     begin
                        speed_in  = wpm_c;
                        pushed_in = {1'b0, wpm_c};
                        if (open_ff) begin
                           res_in.event_res = kh_pkg::EV_HOST;
                           res_in.value     = {4'd0, kh_pkg::pot_byte(wpm_c, potlo_ff)};
                           state_in         = ST_EMIT;
                        end
                     end
                  end
                  default: begin
                     if (open_ff && primed_ff) begin
                        res_in.event_res = kh_pkg::EV_HOST;
                        res_in.value     = {4'd0, up};
                        state_in         = ST_EMIT;
                     end
                  end
               endcase
            end
         end
         ST_ACT: begin
            state_in            = ST_IDLE;
            res_in.last         = 1'b1;
            res_in.continuation = 1'b0;
            case (pend_ff)
               kh_pkg::HC_SPEED: begin
                  if (p0_ff != 8'd0) begin
                     speed_in  = kh_pkg::sat_wpm(p0_ff);
                     pushed_in = {1'b0, kh_pkg::sat_wpm(p0_ff)};
                     res_in.event_res = kh_pkg::EV_SPEED;
                     res_in.value     = {5'd0, kh_pkg::sat_wpm(p0_ff)};
                     state_in         = ST_EMIT;
                  end
               end
               kh_pkg::HC_TONE: begin
                  res_in.event_res = kh_pkg::EV_TONE;
                  res_in.value     = kh_pkg::tone_hz(p0_ff[3:0]);
                  state_in         = ST_EMIT;
               end
               kh_pkg::HC_BKSP: begin
                  if (cnt_ff != '0) cnt_in = cnt_ff - CW'(1);
               end
               kh_pkg::HC_CLEAR: begin
                  cnt_in  = '0;
                  head_in = '0;
                  cont_in = 1'b0;
                  res_in.event_res = kh_pkg::EV_STOP;
                  res_in.value     = 12'd0;
                  state_in         = ST_EMIT;
               end
               kh_pkg::HC_KEY: begin
                  res_in.event_res = kh_pkg::EV_KEY;
                  res_in.value     = {11'd0, p0_ff != 8'd0};
                  state_in         = ST_EMIT;
               end
               kh_pkg::HC_STATUS: begin
                  primed_in        = 1'b1;
                  res_in.event_res = kh_pkg::EV_HOST;
                  res_in.value     = {4'd0, status};
                  state_in         = ST_EMIT;
               end
               kh_pkg::HC_GETPOT: begin
                  primed_in        = 1'b1;
                  res_in.event_res = kh_pkg::EV_HOST;
                  res_in.value     = {4'd0, kh_pkg::pot_byte(speed_ff, potlo_ff)};
                  state_in         = ST_EMIT;
               end
               kh_pkg::HC_POTSET: potlo_in = kh_pkg::sat_wpm(p0_ff);
               // timing and weight settings have no visible effect here
               default: ;
            endcase
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_VALS: begin
            if (out_free) begin
               out_valid_in             = 1'b1;
               out_data_in.event_res    = kh_pkg::EV_HOST;
               out_data_in.value        = (vals_ff == 4'd1) ? {5'd0, speed_ff} : 12'd0;
               out_data_in.last         = (vals_ff == kh_pkg::VALUES_LAST);
               out_data_in.continuation = 1'b0;
               vals_in = vals_ff + 4'd1;
               if (vals_ff == kh_pkg::VALUES_LAST) state_in = ST_IDLE;
            end
         end
         ST_DRAIN_RD: state_in = ST_DRAIN_WR;
         ST_DRAIN_WR: begin
            if (out_free) begin
               out_valid_in             = 1'b1;
               out_data_in.event_res    = kh_pkg::EV_TEXT;
               out_data_in.value        = {4'd0, rdq_ff};
               out_data_in.last         = (rem_ff == 6'd1);
               out_data_in.continuation = dcont_ff;
               head_in = head_nx;
               cnt_in  = cnt_ff - CW'(1);
               rem_in  = rem_ff - 6'd1;
               state_in = (rem_ff == 6'd1) ? ST_IDLE : ST_DRAIN_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= kh_pkg::PM_IDLE;
         pend_ff      <= 5'd0;
         seen_ff      <= 4'd0;
         want_ff      <= 4'd0;
         open_ff      <= 1'b0;
         primed_ff    <= 1'b0;
         speed_ff     <= kh_pkg::SPEED_RST;
         pushed_ff    <= kh_pkg::WPM_NONE;
         potlo_ff     <= kh_pkg::POT_LOW_RST;
         cnt_ff       <= '0;
         head_ff      <= '0;
         cont_ff      <= 1'b0;
         pbusy_ff     <= 1'b0;
         pne_ff       <= 1'b0;
         rem_ff       <= 6'd0;
         vals_ff      <= 4'd0;
         dcont_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         pend_ff      <= pend_in;
         seen_ff      <= seen_in;
         want_ff      <= want_in;
         open_ff      <= open_in;
         primed_ff    <= primed_in;
         speed_ff     <= speed_in;
         pushed_ff    <= pushed_in;
         potlo_ff     <= potlo_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         cont_ff      <= cont_in;
         pbusy_ff     <= pbusy_in;
         pne_ff       <= pne_in;
         rem_ff       <= rem_in;
         vals_ff      <= vals_in;
         dcont_ff     <= dcont_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff       <= p0_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
   end

   // text queue storage
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_DRAIN_RD) begin
         rdq_ff <= mem[head_ff];
      end
   end

endmodule

FILE: rtl/keyer_host_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyer_host_command_parser
// Morse keyer host protocol parser: host bytes, poll ticks, local speed
// changes and decoded-character echo in; host replies and keyer events out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item (command, data_byte, consumer_busy, local_wpm),
//   taken when req_valid is high and req_stall low. rsp_* returns the
//   resulting events, each taken when rsp_valid is high and rsp_stall low;
//   the final event of an item has last set. Items that cause no event
//   produce nothing on rsp_*.
//   An item enters a two-entry input queue, then the executor takes it one
//   at a time. A single-event item has its event built in the result register,
//   then loaded into the output register. Get-values replies send 14 bytes, one
//   per cycle while rsp_stall is low; a poll with the consumer idle drains the text
//   queue, a memory read then an output load per character, up to 32 characters.
//   When rsp_stall is high the output register holds its event, the executor
//   waits and the input queue fills, then req_stall rises.
//   Reset clears all control state; the text queue needs no clearing pass.
//   Configuration registers sit on the APB port at 0x0, 0x4 and 0x8.
// ----------------------------------------------------------------------------
module keyer_host_command_parser #(
   parameter int QUEUE_DEPTH = 32,
   parameter int XOFF_LEVEL  = 24
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  kh_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output kh_pkg::rsp_type rsp_data,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [3:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   logic [7:0]       cfg_version_ff;
   logic [6:0]       cfg_pot_low_ff;
   logic [6:0]       cfg_pot_high_ff;
   logic             cfg_we;
   kh_pkg::link_type link;
   logic             pop;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_version_ff  <= kh_pkg::VERSION_RST;
         cfg_pot_low_ff  <= kh_pkg::POT_LOW_RST;
         cfg_pot_high_ff <= kh_pkg::POT_HIGH_RST;
      end else if (cfg_we) begin
         case (paddr[3:2])
            kh_pkg::REG_VERSION:  cfg_version_ff  <= pwdata[7:0];
            kh_pkg::REG_POT_LOW:  cfg_pot_low_ff  <= pwdata[6:0];
            kh_pkg::REG_POT_HIGH: cfg_pot_high_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         kh_pkg::REG_VERSION:  prdata = {24'd0, cfg_version_ff};
         kh_pkg::REG_POT_LOW:  prdata = {25'd0, cfg_pot_low_ff};
         kh_pkg::REG_POT_HIGH: prdata = {25'd0, cfg_pot_high_ff};
         default:              prdata = 32'd0;
      endcase
   end

   kh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .link      (link),
      .pop       (pop)
   );

   kh_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .XOFF_LEVEL  (XOFF_LEVEL)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .link        (link),
      .pop         (pop),
      .cfg_version (cfg_version_ff),
      .cfg_pot_low (cfg_pot_low_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: rtl/kh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kh_checker
// Port-level checks for the keyer host command parser.
// ----------------------------------------------------------------------------
module kh_checker (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input kh_pkg::rsp_type rsp_data,
   input logic            pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_cont_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_res != kh_pkg::EV_TEXT |-> !rsp_data.continuation)
      else $error("continuation set on a non-text event");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.event_res != 3'd6 && rsp_data.event_res != 3'd7)
      else $error("undefined event code");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

endmodule

bind keyer_host_command_parser kh_checker u_kh_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .pready    (pready)
);
